### rtl/core/pial_pkg.sv
// ----------------------------------------------------------------------------
// pial_pkg
// Shared types and constants for the positional insert array list.
// ----------------------------------------------------------------------------
package pial_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic [STAT_W-1:0]        stat_t;

  localparam stat_t ST_OK      = 2'd0;
  localparam stat_t ST_BAD_POS = 2'd1;
  localparam stat_t ST_FULL    = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOCATE = 1'b1;

  // request bundle from the sequencer to the entry store
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    val_t  wr_data;
  } mem_req_t;

endpackage

### rtl/core/pial_in_if.sv
// ----------------------------------------------------------------------------
// pial_in_if
// Request channel: mode, position and value with valid/ready.
// ----------------------------------------------------------------------------
interface pial_in_if;
  logic           valid;
  logic           ready;
  logic           mode;
  pial_pkg::pos_t position;
  pial_pkg::val_t value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

### rtl/core/pial_out_if.sv
// ----------------------------------------------------------------------------
// pial_out_if
// Result channel: status, found position and list length with valid/ready.
// ----------------------------------------------------------------------------
interface pial_out_if;
  logic            valid;
  logic            ready;
  pial_pkg::stat_t status;
  pial_pkg::pos_t  found_position;
  pial_pkg::len_t  list_length;

  modport source (output valid, output status, output found_position, output list_length,
                  input ready);
  modport sink   (input valid, input status, input found_position, input list_length,
                  output ready);
endinterface

### rtl/core/pial_store.sv
// ----------------------------------------------------------------------------
// pial_store
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pial_store (
  input  logic               clk,
  input  pial_pkg::mem_req_t req,
  output pial_pkg::val_t     rd_data
);
  import pial_pkg::*;

  val_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### rtl/core/positional_insert_array_list.sv
// ----------------------------------------------------------------------------
// positional_insert_array_list
// Ordered list of signed words in a single-port-write entry store.
// Insert at 1-based position n: entries n..L move up one slot, from the tail down
// (one store read per shifted entry, then the new word is written); appending shifts none.
// Locate: one entry compared per cycle off the store read, from position 1 to first match.
// Rejected inserts and empty-list locates go straight to the result. One item at a time;
// the next word is taken while a result waits in the output register.
// Reset clears the length and control state only; store contents stay undefined, no sweep.
// ----------------------------------------------------------------------------
module positional_insert_array_list (
  input  logic        clk,
  input  logic        rst_n,
  pial_in_if.sink     in_ch,
  pial_out_if.source  out_ch
);
  import pial_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  len_t       cnt_r, cnt_nxt;
  addr_t      ptr_r, ptr_nxt;
  addr_t      base_r, base_nxt;
  addr_t      rd_addr_r, rd_addr_nxt;
  logic       rd_more_r, rd_more_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  val_t       val_r, val_nxt;
  stat_t      res_stat_r, res_stat_nxt;
  pos_t       res_found_r, res_found_nxt;

  logic       out_valid_r;
  stat_t      out_stat_r;
  pos_t       out_found_r;
  len_t       out_len_r;

  mem_req_t   mem_req;
  val_t       rd_data;
  logic       accept;
  logic       out_load;
  addr_t      last_addr;

  pial_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign last_addr   = ADDR_W'(cnt_r - len_t'(1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    base_nxt      = base_r;
    rd_addr_nxt   = rd_addr_r;
    rd_more_nxt   = rd_more_r;
    rd_pend_nxt   = 1'b0;
    val_nxt       = val_r;
    res_stat_nxt  = res_stat_r;
    res_found_nxt = res_found_r;
    mem_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt       = in_ch.value;
          res_stat_nxt  = ST_OK;
          res_found_nxt = '0;
          if (in_ch.mode == MODE_INSERT) begin
            if (in_ch.position == '0 ||
                in_ch.position > POS_W'(cnt_r + len_t'(1))) begin
              res_stat_nxt = ST_BAD_POS;
              state_nxt    = S_DONE;
            end else if (cnt_r == len_t'(CAPACITY)) begin
              res_stat_nxt = ST_FULL;
              state_nxt    = S_DONE;
            end else begin
              base_nxt    = ADDR_W'(in_ch.position - pos_t'(1));
              ptr_nxt     = last_addr;
              // no shifting when appending at the tail
              rd_more_nxt = (POS_W'(cnt_r) >= in_ch.position);
              state_nxt   = S_SHIFT;
            end
          end else begin
            ptr_nxt     = '0;
            rd_more_nxt = (cnt_r != '0);
            state_nxt   = (cnt_r != '0) ? S_SCAN : S_DONE;
          end
        end
      end

      S_SHIFT: begin
        mem_req.rd_en   = rd_more_r;
        mem_req.rd_addr = ptr_r;
        rd_pend_nxt     = rd_more_r;
        rd_addr_nxt     = ptr_r;
        if (rd_more_r) begin
          if (ptr_r == base_r) begin
            rd_more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - addr_t'(1);
          end
        end
        if (rd_pend_r) begin
          // entry read last cycle moves up one slot
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = rd_addr_r + addr_t'(1);
          mem_req.wr_data = rd_data;
        end else if (!rd_more_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = base_r;
          mem_req.wr_data = val_r;
          cnt_nxt         = cnt_r + len_t'(1);
          state_nxt       = S_DONE;
        end
      end

      S_SCAN: begin
        mem_req.rd_en   = rd_more_r;
        mem_req.rd_addr = ptr_r;
        rd_pend_nxt     = rd_more_r;
        rd_addr_nxt     = ptr_r;
        if (rd_more_r) begin
          if (ptr_r == last_addr) begin
            rd_more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + addr_t'(1);
          end
        end
        if (rd_pend_r) begin
          if (rd_data == val_r) begin
            res_found_nxt = POS_W'(rd_addr_r) + pos_t'(1);
            rd_more_nxt   = 1'b0;
            rd_pend_nxt   = 1'b0;
            state_nxt     = S_DONE;
          end else if (!rd_more_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_more_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_more_r <= rd_more_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    base_r      <= base_nxt;
    rd_addr_r   <= rd_addr_nxt;
    val_r       <= val_nxt;
    res_stat_r  <= res_stat_nxt;
    res_found_r <= res_found_nxt;
    if (out_load) begin
      out_stat_r  <= res_stat_r;
      out_found_r <= res_found_r;
      out_len_r   <= cnt_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_stat_r;
  assign out_ch.found_position = out_found_r;
  assign out_ch.list_length    = out_len_r;

  // length never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= len_t'(CAPACITY))
    else $error("list length above capacity");

  // store never reads and writes one entry in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
    else $error("read and write hit the same entry");

  // length only grows, one step at a time
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + len_t'(1))
    else $error("list length changed by other than one");

  // a match is reported only with ok status and within the list
  a_found_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found_position != '0 |->
      out_ch.status == ST_OK && POS_W'(out_ch.list_length) >= out_ch.found_position)
    else $error("found position inconsistent with result");

endmodule
